// ===== src/midpoint_ellipse_point_generator_macros.svh =====
// ----------------------------------------------------------------------------
// Midpoint ellipse point generator assertion macros
// Short forms for the clocked implication checks used by the RTL.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_ELLIPSE_POINT_GENERATOR_MACROS_SVH
`define MIDPOINT_ELLIPSE_POINT_GENERATOR_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication under synchronous reset.
`define MEPG_ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication under synchronous reset.
`define MEPG_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MEPG_ASSERT_IMPL(lbl, ck, rs, ante, cons)
`define MEPG_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif

`endif

// ===== src/mepg_pkg.sv =====
// ----------------------------------------------------------------------------
// mepg_pkg
// Types and constants of the midpoint ellipse point generator.
// ----------------------------------------------------------------------------
package mepg_pkg;

  // Field widths.
  localparam int COORD_W  = 12;
  localparam int RADIUS_W = 11;
  localparam int PIXEL_W  = COORD_W + 2;
  localparam int COLOR_W  = 32;

  // Commands carried in the input beat's tuser bit.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // Register index, taken from the word address bit.
  localparam logic REG_DRAW_COLOR = 1'b0;

  // Last sequencer count of the two multiply sequences.
  localparam logic [2:0] INIT_LAST = 3'd3;
  localparam logic [2:0] R2_LAST   = 3'd5;

  // Drawing region of the algorithm.
  typedef enum logic [1:0] {
    R_IDLE,
    R_ONE,
    R_TWO
  } region_t;

  // Sequencer of the shared multiplier and the decision update.
  typedef enum logic [2:0] {
    C_IDLE,
    C_INIT,
    C_SETTLE,
    C_R2MUL,
    C_ADV,
    C_DEC
  } seq_t;

endpackage

// ===== src/midpoint_ellipse_point_generator.sv =====
// Step beat: the first three pixel beats leave one per cycle while m_tready
// holds high, and the fourth once the update has settled; the next beat is
// taken once the update and the emitter are both done, later on the step
// that enters region two (its multiply sequence and a second settle).
// Start beat: the initial multiply sequence plus settle, with no output.
// Synchronous active-high reset clears the sequencer, region and color.
// ----------------------------------------------------------------------------
// midpoint_ellipse_point_generator
// Midpoint ellipse rasterizer with one shared 26x26 multiplier under a
// small sequencer; decision values are kept at four times their real value.
// ----------------------------------------------------------------------------
`include "midpoint_ellipse_point_generator_macros.svh"

module midpoint_ellipse_point_generator
  import mepg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // center_x, center_y, half_width, half_height
  input  logic        s_tuser,   // command
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // pixel_x, pixel_y, pixel_color
  output logic        m_tlast,   // last_of_step
  output logic        m_tuser,   // ellipse_done
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration register.
  logic [COLOR_W-1:0] draw_color;

  // Sequencer and algorithm state.
  seq_t    cstate, cstate_next;
  region_t region;
  logic [2:0] mcnt;

  logic [COORD_W-1:0]  cx, cy;
  logic [RADIUS_W-1:0] rx, ry;
  logic [2*RADIUS_W-1:0] rx2, ry2;
  logic [COORD_W-1:0]  step_x;
  logic signed [COORD_W:0] step_y;
  logic signed [35:0] delta_x, delta_y;
  logic signed [47:0] decision;
  logic take;

  // Shared multiplier and its scratch registers.
  logic [25:0] mul_a, mul_b;
  logic [51:0] mul_p;
  logic [25:0] sq_a, sq_b;
  logic [51:0] acc;

  // Emitter.
  logic emit_busy;
  logic [1:0] emit_cnt;
  logic emit_load;
  logic [COORD_W-1:0] ex;
  logic signed [COORD_W:0] ey;
  logic [PIXEL_W-1:0] out_x, out_y;
  logic out_last, out_done;

  logic in_accept;
  logic signed [COORD_W:0] ty;
  logic [COORD_W:0] aty;
  logic [COORD_W:0] tx;
  logic signed [47:0] dx_w, dy_w, ry2_w, rx2_w;

  assign in_accept = s_tvalid && s_tready;

  // Configuration port: zero wait, word index in paddr[2].
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DRAW_COLOR) ? draw_color : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      draw_color <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_DRAW_COLOR) begin
      draw_color <= pwdata;
    end
  end

  // Region-two setup terms.
  assign tx  = {step_x, 1'b1};
  assign ty  = step_y - 13'sd1;
  assign aty = ty[COORD_W] ? 13'(-ty) : 13'(ty);

  // Widened operands of the decision update.
  assign dx_w  = 48'(delta_x);
  assign dy_w  = 48'(delta_y);
  assign ry2_w = $signed({26'd0, ry2});
  assign rx2_w = $signed({26'd0, rx2});

  // Next-state logic of the sequencer.
  always_comb begin
    cstate_next = cstate;
    case (cstate)
      C_IDLE: begin
        if (in_accept) begin
          if (s_tuser == CMD_START) begin
            cstate_next = C_INIT;
          end else if (region != R_IDLE) begin
            cstate_next = C_ADV;
          end
        end
      end
      C_INIT: begin
        if (mcnt == INIT_LAST) cstate_next = C_SETTLE;
      end
      C_ADV: cstate_next = C_DEC;
      C_DEC: cstate_next = C_SETTLE;
      C_SETTLE: begin
        if (region == R_ONE && !(delta_x < delta_y)) begin
          cstate_next = C_R2MUL;
        end else begin
          cstate_next = C_IDLE;
        end
      end
      C_R2MUL: begin
        if (mcnt == R2_LAST) cstate_next = C_SETTLE;
      end
      default: cstate_next = C_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and multiplier operand selection.
  always_comb begin
    s_tready = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    case (cstate)
      C_IDLE: s_tready = !emit_busy;
      C_INIT: begin
        case (mcnt)
          3'd0: begin mul_a = 26'(rx);  mul_b = 26'(rx); end
          3'd1: begin mul_a = 26'(ry);  mul_b = 26'(ry); end
          3'd2: begin mul_a = 26'(rx2); mul_b = 26'(ry); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      C_R2MUL: begin
        case (mcnt)
          3'd0: begin mul_a = 26'(tx);  mul_b = 26'(tx);  end
          3'd1: begin mul_a = 26'(aty); mul_b = 26'(aty); end
          3'd2: begin mul_a = 26'(ry2); mul_b = sq_a;     end
          3'd3: begin mul_a = 26'(rx2); mul_b = sq_b;     end
          3'd4: begin mul_a = 26'(rx2); mul_b = 26'(ry2); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      default: s_tready = 1'b0;
    endcase
  end

  // Shared multiplier with registered product.
  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  // Control registers of the sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      cstate <= C_IDLE;
      region <= R_IDLE;
      mcnt   <= '0;
    end else begin
      cstate <= cstate_next;
      mcnt   <= (cstate_next == cstate && (cstate == C_INIT || cstate == C_R2MUL))
                ? mcnt + 3'd1 : 3'd0;
      case (cstate)
        C_IDLE: begin
          if (in_accept && s_tuser == CMD_START) region <= R_ONE;
        end
        C_R2MUL: begin
          if (mcnt == R2_LAST) region <= R_TWO;
        end
        C_SETTLE: begin
          if (region == R_TWO && step_y < 0) region <= R_IDLE;
        end
        default: region <= region;
      endcase
    end
  end

  // Datapath of the algorithm.
  always_ff @(posedge clk) begin
    case (cstate)
      C_IDLE: begin
        if (in_accept && s_tuser == CMD_START) begin
          cx      <= s_tdata[11:0];
          cy      <= s_tdata[23:12];
          rx      <= s_tdata[34:24];
          ry      <= s_tdata[45:35];
          step_x  <= '0;
          step_y  <= $signed({2'b00, s_tdata[45:35]});
          delta_x <= '0;
        end else if (in_accept) begin
          ex <= step_x;
          ey <= step_y;
        end
      end
      C_INIT: begin
        case (mcnt)
          3'd1: rx2 <= mul_p[21:0];
          3'd2: ry2 <= mul_p[21:0];
          3'd3: begin
            delta_y  <= $signed({mul_p[34:0], 1'b0});
            decision <= $signed(({26'd0, ry2} << 2) + {26'd0, rx2}
                                - (mul_p[47:0] << 2));
          end
          default: decision <= decision;
        endcase
      end
      C_R2MUL: begin
        case (mcnt)
          3'd1: sq_a <= mul_p[25:0];
          3'd2: sq_b <= mul_p[25:0];
          3'd3: acc <= mul_p;
          3'd4: acc <= acc + (mul_p << 2);
          3'd5: decision <= $signed(48'(acc - (mul_p << 2)));
          default: acc <= acc;
        endcase
      end
      // Coordinate and slope update; the sign test uses the old decision.
      C_ADV: begin
        if (region == R_ONE) begin
          take    <= !decision[47];
          step_x  <= step_x + 12'd1;
          delta_x <= delta_x + $signed({13'd0, ry2, 1'b0});
          if (!decision[47]) begin
            step_y  <= step_y - 13'sd1;
            delta_y <= delta_y - $signed({13'd0, rx2, 1'b0});
          end
        end else begin
          take    <= decision[47] || decision == 48'sd0;
          step_y  <= step_y - 13'sd1;
          delta_y <= delta_y - $signed({13'd0, rx2, 1'b0});
          if (decision[47] || decision == 48'sd0) begin
            step_x  <= step_x + 12'd1;
            delta_x <= delta_x + $signed({13'd0, ry2, 1'b0});
          end
        end
      end
      // Decision update with the new slopes.
      C_DEC: begin
        if (region == R_ONE) begin
          decision <= decision + (ry2_w <<< 2) + (dx_w <<< 2)
                      - (take ? (dy_w <<< 2) : 48'sd0);
        end else begin
          decision <= decision + (rx2_w <<< 2) - (dy_w <<< 2)
                      + (take ? (dx_w <<< 2) : 48'sd0);
        end
      end
      default: decision <= decision;
    endcase
  end

  // Pixel emitter; the fourth pixel waits for the step's settle to finish.
  assign emit_load = emit_busy && (!m_tvalid || m_tready)
                     && (emit_cnt != 2'd3 || cstate == C_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_busy <= 1'b0;
      emit_cnt  <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (in_accept && s_tuser == CMD_STEP && region != R_IDLE) begin
        emit_busy <= 1'b1;
        emit_cnt  <= '0;
      end else if (emit_load) begin
        emit_cnt <= emit_cnt + 2'd1;
        if (emit_cnt == 2'd3) emit_busy <= 1'b0;
      end
      if (emit_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Output payload: x mirrors on count bit 0, y on count bit 1.
  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_x    <= emit_cnt[0] ? ({2'b00, cx} - {2'b00, ex}) : ({2'b00, cx} + {2'b00, ex});
      out_y    <= emit_cnt[1] ? ({2'b00, cy} - {ey[COORD_W], ey})
                              : ({2'b00, cy} + {ey[COORD_W], ey});
      out_last <= emit_cnt == 2'd3;
      out_done <= emit_cnt == 2'd3 && region == R_IDLE;
    end
  end

  assign m_tdata = {4'd0, draw_color, out_y, out_x};
  assign m_tlast = out_last;
  assign m_tuser = out_done;

  // A step on an active ellipse starts both the emitter and the update.
  `MEPG_ASSERT_NEXT(a_step_starts, clk, rst, in_accept && s_tuser == CMD_STEP && region != R_IDLE, emit_busy && cstate == C_ADV)
  // The done flag only ever rides on the last pixel of a step.
  `MEPG_ASSERT_IMPL(a_done_on_last, clk, rst, m_tvalid && m_tuser, m_tlast)
  // The update states only run on an ellipse in progress.
  `MEPG_ASSERT_IMPL(a_adv_active, clk, rst, cstate == C_ADV || cstate == C_DEC, region != R_IDLE)

endmodule
